/* design/imh_pkg.sv */
// ----------------------------------------------------------------------------
// imh_pkg: indexed min-heap queue shared types
// Entry layout, operation and status codes, and memory request bundles.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int CAPACITY  = 64;
  localparam int ID_COUNT  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int ID_W      = 6;
  localparam int SLOT_W    = 7;
  localparam int ADDR_W    = $clog2(CAPACITY);

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [ID_W-1:0]             id_t;
  typedef logic [SLOT_W-1:0]           slot_t;
  typedef logic [ADDR_W-1:0]           addr_t;

  typedef struct packed {
    key_t key;
    id_t  id;
  } entry_t;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_REM  = 2'd2,
    OP_PEEK = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4
  } status_e;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr_a;
    addr_t  raddr_b;
  } heap_req_t;

  typedef struct packed {
    logic  we;
    id_t   waddr;
    slot_t wdata;
    id_t   raddr;
  } slot_req_t;

endpackage

/* design/indexed_min_heap_queue_core.sv */
// Peek and failed requests go from decode straight to done; enqueue and dequeue
// walk the heap one level per comparison as far as needed before the final write,
// and remove first fetches the entry at its slot and then walks the heap likewise.
// Throughput: one request at a time; the next request is taken the cycle after
// the response is registered, and output stalls hold the sequencer in done.
// Reset: asynchronous, active low; empties the queue and the id table.
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_core: indexed binary min-heap priority queue
// Sequencer walking sift-up / sift-down over the heap memory, one level a cycle.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [5:0]  entry_id_i,
  input  logic [31:0] priority_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [5:0]  result_id_o,
  output logic [31:0] result_priority_o,
  output logic [6:0]  entry_count_o
);

  localparam int SW = imh_pkg::SLOT_W;
  localparam int AW = imh_pkg::ADDR_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_RM_GOT = 7'b0000100,
    S_UP     = 7'b0001000,
    S_DOWN   = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  imh_pkg::op_e       op_q, op_d;
  imh_pkg::id_t       id_q, id_d;
  imh_pkg::key_t      key_q, key_d;
  imh_pkg::slot_t     cnt_q, cnt_d;
  imh_pkg::slot_t     s_q, s_d;
  imh_pkg::entry_t    cur_q, cur_d;
  imh_pkg::entry_t    last_q, last_d;
  logic               moved_q, moved_d;
  imh_pkg::status_e   rst_q, rst_d;
  imh_pkg::id_t       rid_q, rid_d;
  imh_pkg::key_t      rkey_q, rkey_d;

  logic               out_valid_q;
  imh_pkg::status_e   out_status_q;
  imh_pkg::id_t       out_id_q;
  imh_pkg::key_t      out_key_q;
  imh_pkg::slot_t     out_cnt_q;

  imh_pkg::heap_req_t heap_req;
  imh_pkg::slot_req_t slot_req;
  imh_pkg::entry_t    heap_a, heap_b;
  imh_pkg::slot_t     slot_rd;

  imh_heap_mem u_heap (
    .clk_i     (clk_i),
    .req_i     (heap_req),
    .rdata_a_o (heap_a),
    .rdata_b_o (heap_b)
  );

  imh_slot_tab u_slot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (slot_req),
    .rdata_o (slot_rd)
  );

  // child selection for sift-down
  logic [SW:0]     ch_slot2;
  logic            pick_b;
  imh_pkg::entry_t ch_ent;
  imh_pkg::slot_t  ch_slot;

  assign ch_slot2 = {s_q, 1'b0};
  assign pick_b   = (ch_slot2 < {1'b0, cnt_q}) && ($signed(heap_a.key) > $signed(heap_b.key));
  assign ch_ent   = pick_b ? heap_b : heap_a;
  assign ch_slot  = pick_b ? SW'(ch_slot2 + 1'b1) : SW'(ch_slot2);

  // next sift-down step: children of dn_from within dn_n entries
  imh_pkg::slot_t dn_from, dn_n;
  logic [SW:0]    dn_child;
  logic           dn_go;

  always_comb begin
    dn_n = (state_q == S_DECODE || state_q == S_RM_GOT) ? SW'(cnt_q - 1'b1) : cnt_q;
    dn_from = s_q;
    if (state_q == S_DECODE) begin
      dn_from = SW'(1);
    end else if (state_q == S_DOWN) begin
      dn_from = ch_slot;
    end
  end

  assign dn_child = {dn_from, 1'b0};
  assign dn_go    = dn_child <= {1'b0, dn_n};

  logic id_ok;
  assign id_ok = {1'b0, id_q} < SW'(imh_pkg::ID_COUNT);

  imh_pkg::slot_t parent;
  assign parent = s_q >> 1;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    id_d     = id_q;
    key_d    = key_q;
    cnt_d    = cnt_q;
    s_d      = s_q;
    cur_d    = cur_q;
    last_d   = last_q;
    moved_d  = moved_q;
    rst_d    = rst_q;
    rid_d    = rid_q;
    rkey_d   = rkey_q;
    heap_req = '0;
    slot_req = '0;
    heap_req.raddr_a = AW'(dn_child - 1'b1);
    heap_req.raddr_b = AW'(dn_child);
    slot_req.raddr   = entry_id_i;

    unique case (state_q)
      S_IDLE: begin
        heap_req.raddr_a = '0;
        heap_req.raddr_b = AW'(cnt_q - 1'b1);
        if (in_valid_i) begin
          op_d    = imh_pkg::op_e'(op_i);
          id_d    = entry_id_i;
          key_d   = priority_req_i[imh_pkg::KEY_WIDTH-1:0];
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        last_d  = heap_b;
        rst_d   = imh_pkg::ST_OK;
        rkey_d  = '0;
        rid_d   = id_q;
        moved_d = 1'b0;
        unique case (op_q)
          imh_pkg::OP_ENQ: begin
            if (!id_ok) begin
              rst_d   = imh_pkg::ST_ABSENT;
              state_d = S_DONE;
            end else if (slot_rd != '0) begin
              rst_d   = imh_pkg::ST_DUP;
              state_d = S_DONE;
            end else if (cnt_q >= SW'(imh_pkg::CAPACITY)) begin
              rst_d   = imh_pkg::ST_FULL;
              state_d = S_DONE;
            end else begin
              rkey_d = key_q;
              cur_d  = '{key: key_q, id: id_q};
              s_d    = SW'(cnt_q + 1'b1);
              cnt_d  = SW'(cnt_q + 1'b1);
              heap_req.raddr_a = AW'(SW'(SW'(cnt_q + 1'b1) >> 1) - 1'b1);
              state_d = (cnt_q == '0) ? S_FIN : S_UP;
            end
          end
          imh_pkg::OP_DEQ, imh_pkg::OP_PEEK: begin
            rid_d = '0;
            if (cnt_q == '0) begin
              rst_d   = imh_pkg::ST_EMPTY;
              state_d = S_DONE;
            end else begin
              rid_d  = heap_a.id;
              rkey_d = heap_a.key;
              if (op_q == imh_pkg::OP_PEEK) begin
                state_d = S_DONE;
              end else begin
                slot_req.we    = 1'b1;
                slot_req.waddr = heap_a.id;
                slot_req.wdata = '0;
                cnt_d = SW'(cnt_q - 1'b1);
                cur_d = heap_b;
                s_d   = SW'(1);
                if (cnt_q == SW'(1)) begin
                  state_d = S_DONE;
                end else begin
                  state_d = dn_go ? S_DOWN : S_FIN;
                end
              end
            end
          end
          default: begin
            if (cnt_q == '0) begin
              rst_d   = imh_pkg::ST_EMPTY;
              state_d = S_DONE;
            end else if (!id_ok || slot_rd == '0 || slot_rd > cnt_q) begin
              rst_d   = imh_pkg::ST_ABSENT;
              state_d = S_DONE;
            end else begin
              s_d = slot_rd;
              heap_req.raddr_a = AW'(slot_rd - 1'b1);
              state_d = S_RM_GOT;
            end
          end
        endcase
      end
      S_RM_GOT: begin
        rkey_d = heap_a.key;
        slot_req.we    = 1'b1;
        slot_req.waddr = id_q;
        slot_req.wdata = '0;
        cnt_d = SW'(cnt_q - 1'b1);
        cur_d = last_q;
        if (s_q == cnt_q) begin
          state_d = S_DONE;
        end else if (s_q > SW'(1)) begin
          heap_req.raddr_a = AW'(parent - 1'b1);
          state_d = S_UP;
        end else begin
          state_d = dn_go ? S_DOWN : S_FIN;
        end
      end
      S_UP: begin
        if ($signed(cur_q.key) < $signed(heap_a.key)) begin
          heap_req.we    = 1'b1;
          heap_req.waddr = AW'(s_q - 1'b1);
          heap_req.wdata = heap_a;
          slot_req.we    = 1'b1;
          slot_req.waddr = heap_a.id;
          slot_req.wdata = s_q;
          s_d     = parent;
          moved_d = 1'b1;
          heap_req.raddr_a = AW'(SW'(parent >> 1) - 1'b1);
          state_d = (parent > SW'(1)) ? S_UP : S_FIN;
        end else if (op_q == imh_pkg::OP_REM && !moved_q) begin
          state_d = dn_go ? S_DOWN : S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DOWN: begin
        if ($signed(ch_ent.key) < $signed(cur_q.key)) begin
          heap_req.we    = 1'b1;
          heap_req.waddr = AW'(s_q - 1'b1);
          heap_req.wdata = ch_ent;
          slot_req.we    = 1'b1;
          slot_req.waddr = ch_ent.id;
          slot_req.wdata = s_q;
          s_d     = ch_slot;
          state_d = dn_go ? S_DOWN : S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        heap_req.we    = 1'b1;
        heap_req.waddr = AW'(s_q - 1'b1);
        heap_req.wdata = cur_q;
        slot_req.we    = 1'b1;
        slot_req.waddr = cur_q.id;
        slot_req.wdata = s_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      moved_q <= moved_d;
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    id_q   <= id_d;
    key_q  <= key_d;
    s_q    <= s_d;
    cur_q  <= cur_d;
    last_q <= last_d;
    rst_q  <= rst_d;
    rid_q  <= rid_d;
    rkey_q <= rkey_d;
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_status_q <= rst_q;
      out_id_q     <= rid_q;
      out_key_q    <= rkey_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign result_id_o       = out_id_q;
  assign result_priority_o = 32'(out_key_q);
  assign entry_count_o     = out_cnt_q;

endmodule

/* design/imh_heap_mem.sv */
// ----------------------------------------------------------------------------
// imh_heap_mem: heap slot storage
// One write port, two registered read ports; index is heap slot minus one.
// ----------------------------------------------------------------------------
module imh_heap_mem (
  input  logic               clk_i,
  input  imh_pkg::heap_req_t req_i,
  output imh_pkg::entry_t    rdata_a_o,
  output imh_pkg::entry_t    rdata_b_o
);

  imh_pkg::entry_t mem_q [imh_pkg::CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_o <= mem_q[req_i.raddr_a];
    rdata_b_o <= mem_q[req_i.raddr_b];
  end

endmodule

/* design/imh_slot_tab.sv */
// ----------------------------------------------------------------------------
// imh_slot_tab: id to heap slot table
// Registered read; per-id valid bits make unwritten ids read as slot zero.
// ----------------------------------------------------------------------------
module imh_slot_tab (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imh_pkg::slot_req_t req_i,
  output imh_pkg::slot_t     rdata_o
);

  imh_pkg::slot_t              mem_q [imh_pkg::ID_COUNT];
  logic [imh_pkg::ID_COUNT-1:0] vld_q;
  imh_pkg::slot_t              rd_q;
  logic                        rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      rd_vld_q <= vld_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule
